[hdl/salru_pkg.sv]
// Shared constants for the set-associative LRU tag lookup block.
// No dependencies; used by set_assoc_cache_lru_lookup.sv.
`default_nettype none

package salru_pkg;

   // Address split
   localparam int ADDR_BITS   = 32;
   localparam int OFFSET_BITS = 2;

   // Default geometry
   localparam int NUM_SETS_DEF = 2;
   localparam int NUM_WAYS_DEF = 4;

   // Result fields
   localparam int WAY_USED_W = 2;
   localparam int COUNT_W    = 32;
   localparam int RSP_FIELD_W = 1 + WAY_USED_W + 2 * COUNT_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

endpackage

`default_nettype wire

[hdl/salru_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module salru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[hdl/set_assoc_cache_lru_lookup.sv]
// Set-associative cache tag lookup with true LRU replacement, counters and stream ports.
// Depends on salru_pkg and salru_ram.
//
// One byte address goes in per transfer and one result comes out per transfer, in order.
// The line offset is address bits [1:0], the set is the next log2(NUM_SETS) bits
// (NUM_SETS must be a power of two) and the tag is everything above. Each set is one
// row of a RAM holding the valid bits, tags and recency order of all its ways; the row
// is read as the address is taken and written back when the result is registered, with
// a bypass register for back-to-back accesses to the same set. Steady state is one
// address per cycle while the result side does not stall. The address and its set row
// are registered in the lookup stage, and the result is registered when that stage
// advances. After reset a clearing pass writes every set row while req_tready is low.
// Hit and access counts saturate at all ones.
`default_nettype none

module set_assoc_cache_lru_lookup #(
   parameter int NUM_SETS = salru_pkg::NUM_SETS_DEF,
   parameter int NUM_WAYS = salru_pkg::NUM_WAYS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request stream
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [salru_pkg::ADDR_BITS-1:0]   req_tdata,   // [31:0] address
   // result stream
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [salru_pkg::RSP_DATA_W-1:0]       rsp_tdata    // [0] hit, [2:1] way_used,
                                                               // [34:3] hit_count,
                                                               // [66:35] access_count, rest 0
);

   localparam int SET_LOG = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 0;
   localparam int SI_W    = (NUM_SETS > 1) ? SET_LOG : 1;
   localparam int TAG_LO_BIT = salru_pkg::OFFSET_BITS + SET_LOG;
   localparam int TAG_W   = salru_pkg::ADDR_BITS - TAG_LO_BIT;
   localparam int WB      = $clog2(NUM_WAYS);
   localparam int TAG_LO  = NUM_WAYS;
   localparam int ORD_LO  = NUM_WAYS + NUM_WAYS * TAG_W;
   localparam int ROW_W   = NUM_WAYS * (1 + TAG_W + WB);
   localparam int CW      = salru_pkg::COUNT_W;

   // row after reset: nothing valid, order NUM_WAYS-1 .. 0
   function automatic logic [ROW_W-1:0] init_row();
      logic [ROW_W-1:0] r;
      r = '0;
      for (int p = 0; p < NUM_WAYS; p++) begin
         r[ORD_LO + p * WB +: WB] = WB'(NUM_WAYS - 1 - p);
      end
      return r;
   endfunction

   // handshake and pipeline control
   logic             accept;
   logic             s1_adv;
   logic             s1_valid_ff, s1_valid_in;
   logic [TAG_W-1:0] s1_tag_ff;
   logic [SI_W-1:0]  s1_set_ff;
   logic [SI_W-1:0]  req_set;
   logic [TAG_W-1:0] req_tag;

   // clearing pass
   logic             clr_active_ff, clr_active_in;
   logic [SI_W-1:0]  clr_idx_ff, clr_idx_in;

   // set row storage and bypass
   logic             ram_wr_en;
   logic [SI_W-1:0]  ram_wr_addr;
   logic [ROW_W-1:0] ram_wr_data;
   logic [ROW_W-1:0] ram_rd_data;
   logic [ROW_W-1:0] fwd_row_ff;
   logic             fwd_sel_ff, fwd_sel_in;

   // lookup
   logic [ROW_W-1:0] cur_row;
   logic [ROW_W-1:0] row_in;
   logic             cur_vld [NUM_WAYS];
   logic [TAG_W-1:0] cur_tag [NUM_WAYS];
   logic [WB-1:0]    cur_ord [NUM_WAYS];
   logic             new_vld [NUM_WAYS];
   logic [TAG_W-1:0] new_tag [NUM_WAYS];
   logic [WB-1:0]    new_ord [NUM_WAYS];
   logic             hit;
   logic [WB-1:0]    hit_way;
   logic [WB-1:0]    used;
   logic [WB-1:0]    pos;

   // results and counters
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_hit_ff;
   logic [salru_pkg::WAY_USED_W-1:0] rsp_way_ff;
   logic [CW-1:0]    hits_ff, hits_in;
   logic [CW-1:0]    accs_ff, accs_in;

   // address split
   assign req_set = (NUM_SETS > 1) ? req_tdata[salru_pkg::OFFSET_BITS +: SI_W] : '0;
   assign req_tag = req_tdata[salru_pkg::ADDR_BITS-1:TAG_LO_BIT];

   // handshakes
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !clr_active_ff && (!s1_valid_ff || s1_adv);
   assign accept     = req_tvalid && req_tready;

   // row storage: clearing pass, then write-back of each lookup
   assign ram_wr_en   = clr_active_ff || s1_adv;
   assign ram_wr_addr = clr_active_ff ? clr_idx_ff : s1_set_ff;
   assign ram_wr_data = clr_active_ff ? init_row() : row_in;

   salru_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_SETS)
   ) u_rows (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (req_set),
      .rd_data (ram_rd_data)
   );

   // lookup, replacement choice and recency update
   always_comb begin
      cur_row = fwd_sel_ff ? fwd_row_ff : ram_rd_data;
      for (int w = 0; w < NUM_WAYS; w++) begin
         cur_vld[w] = cur_row[w];
         cur_tag[w] = cur_row[TAG_LO + w * TAG_W +: TAG_W];
         cur_ord[w] = cur_row[ORD_LO + w * WB +: WB];
      end

      // lowest matching way wins
      hit     = 1'b0;
      hit_way = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (cur_vld[w] && cur_tag[w] == s1_tag_ff) begin
            hit     = 1'b1;
            hit_way = WB'(w);
         end
      end
      used = hit ? hit_way : cur_ord[NUM_WAYS-1];

      // recency position of the used way
      pos = WB'(NUM_WAYS - 1);
      for (int k = NUM_WAYS - 1; k >= 0; k--) begin
         if (cur_ord[k] == used) begin
            pos = WB'(k);
         end
      end

      // move it to the front
      new_ord[0] = used;
      for (int k = 1; k < NUM_WAYS; k++) begin
         new_ord[k] = (WB'(k) <= pos) ? cur_ord[k-1] : cur_ord[k];
      end

      // fill on miss
      for (int w = 0; w < NUM_WAYS; w++) begin
         new_vld[w] = cur_vld[w];
         new_tag[w] = cur_tag[w];
         if (!hit && used == WB'(w)) begin
            new_vld[w] = 1'b1;
            new_tag[w] = s1_tag_ff;
         end
      end

      row_in = '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         row_in[w] = new_vld[w];
         row_in[TAG_LO + w * TAG_W +: TAG_W] = new_tag[w];
         row_in[ORD_LO + w * WB +: WB]       = new_ord[w];
      end
   end

   // next-state logic
   always_comb begin
      clr_active_in = clr_active_ff;
      clr_idx_in    = clr_idx_ff;
      if (clr_active_ff) begin
         if (clr_idx_ff == SI_W'(NUM_SETS - 1)) begin
            clr_active_in = 1'b0;
         end else begin
            clr_idx_in = clr_idx_ff + 1'b1;
         end
      end

      s1_valid_in = accept || (s1_valid_ff && !s1_adv);
      // bypass when the new address hits the set being written back
      fwd_sel_in  = accept ? (s1_adv && req_set == s1_set_ff) : fwd_sel_ff;

      rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_tready);

      hits_in = hits_ff;
      accs_in = accs_ff;
      if (s1_adv) begin
         if (accs_ff != {CW{1'b1}}) begin
            accs_in = accs_ff + 1'b1;
         end
         if (hit && hits_ff != {CW{1'b1}}) begin
            hits_in = hits_ff + 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_idx_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         fwd_sel_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         hits_ff       <= '0;
         accs_ff       <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_idx_ff    <= clr_idx_in;
         s1_valid_ff   <= s1_valid_in;
         fwd_sel_ff    <= fwd_sel_in;
         rsp_valid_ff  <= rsp_valid_in;
         hits_ff       <= hits_in;
         accs_ff       <= accs_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_tag_ff  <= req_tag;
         s1_set_ff  <= req_set;
         fwd_row_ff <= row_in;
      end
      if (s1_adv) begin
         rsp_hit_ff <= hit;
         rsp_way_ff <= salru_pkg::WAY_USED_W'(used);
      end
   end

   // result transfer; counters only move when a new result is loaded
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {
      {(salru_pkg::RSP_DATA_W - salru_pkg::RSP_FIELD_W){1'b0}},
      accs_ff, hits_ff, rsp_way_ff, rsp_hit_ff
   };

   // checks
   a_hits_le_accs: assert property (@(posedge clock) disable iff (reset)
      hits_ff <= accs_ff)
      else $error("hit count exceeds access count");

   a_fwd_has_item: assert property (@(posedge clock) disable iff (reset)
      fwd_sel_ff && !s1_valid_ff |-> !rsp_valid_ff || $past(rsp_valid_ff))
      else $error("bypass row selected without a pending item");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !accept && !s1_valid_ff)
      else $error("lookup active during clearing pass");

   a_acc_step: assert property (@(posedge clock) disable iff (reset)
      s1_adv && accs_ff != {CW{1'b1}} |=> accs_ff == $past(accs_ff) + 1'b1)
      else $error("access count did not advance with a result");

   a_hit_way_valid: assert property (@(posedge clock) disable iff (reset)
      s1_adv && hit |-> cur_vld[hit_way])
      else $error("hit reported on an invalid way");

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for set_assoc_cache_lru_lookup: 4-way, 2-set tag store with LRU.
// Depends on salru_pkg and the block's RTL; keeps its own tag, valid and recency copy
// to predict hit, way and counts for every address transfer.

module testbench;

   localparam int ADDR_BITS      = salru_pkg::ADDR_BITS;
   localparam int OFFSET_BITS    = salru_pkg::OFFSET_BITS;
   localparam int WAY_USED_W     = salru_pkg::WAY_USED_W;
   localparam int COUNT_W        = salru_pkg::COUNT_W;
   localparam int RSP_DATA_W     = salru_pkg::RSP_DATA_W;
   localparam int NSETS          = salru_pkg::NUM_SETS_DEF;
   localparam int NWAYS          = salru_pkg::NUM_WAYS_DEF;
   localparam int SET_W          = $clog2(NSETS);
   localparam int TAG_W          = ADDR_BITS - OFFSET_BITS - SET_W;
   localparam int PAD_W          = RSP_DATA_W - salru_pkg::RSP_FIELD_W;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 150;
   localparam int SETTLE_CYCLES  = 8;
   localparam int POOL_SIZE      = 8;
   localparam int REPORT_MAX     = 10;

   // result layout, lowest bit last
   typedef struct packed {
      logic [PAD_W-1:0]      pad;
      logic [COUNT_W-1:0]    access_count;
      logic [COUNT_W-1:0]    hit_count;
      logic [WAY_USED_W-1:0] way_used;
      logic                  hit;
   } lookup_rsp_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [ADDR_BITS-1:0]  req_tdata;    // [31:0] address
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;    // [0] hit, [2:1] way_used, [34:3] hit_count,
                                        // [66:35] access_count, rest 0

   // shadow copy of the tag store
   logic [TAG_W-1:0]      shadow_tag   [NSETS][NWAYS];
   logic                  shadow_valid [NSETS][NWAYS];
   logic [WAY_USED_W-1:0] shadow_order [NSETS][NWAYS];  // position 0 = most recent
   logic [COUNT_W-1:0]    shadow_hits;
   logic [COUNT_W-1:0]    shadow_accesses;

   lookup_rsp_type   expected_lookups[$];
   int               fail_count;
   int               stall_left;
   int               quiet_cycles;
   bit               idle_en;
   bit               long_hold_req;
   logic [TAG_W-1:0] tag_pool [POOL_SIZE];
   int               pool_span;

   set_assoc_cache_lru_lookup dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // shadow state after reset: all ways empty, order 3,2,1,0
   function automatic void clear_shadow();
      for (int s = 0; s < NSETS; s++) begin
         for (int p = 0; p < NWAYS; p++) begin
            shadow_tag[s][p]   = '0;
            shadow_valid[s][p] = 1'b0;
            shadow_order[s][p] = WAY_USED_W'(NWAYS - 1 - p);
         end
      end
      shadow_hits     = '0;
      shadow_accesses = '0;
   endfunction

   // lookup one address in the shadow store, update it, return the expected result
   function automatic lookup_rsp_type predict_lookup(input logic [ADDR_BITS-1:0] addr);
      lookup_rsp_type   r;
      int               s;
      int               pos;
      logic [TAG_W-1:0] t;
      bit               found;
      r     = '0;
      s     = int'(addr[OFFSET_BITS +: SET_W]);
      t     = addr[ADDR_BITS-1 -: TAG_W];
      found = 1'b0;
      if (shadow_accesses != '1) shadow_accesses++;
      for (int w = 0; w < NWAYS; w++) begin
         if (!found && shadow_valid[s][w] && shadow_tag[s][w] == t) begin
            found      = 1'b1;
            r.way_used = WAY_USED_W'(w);
         end
      end
      if (found) begin
         if (shadow_hits != '1) shadow_hits++;
      end else begin
         // fill the least recently used way
         r.way_used                  = shadow_order[s][NWAYS-1];
         shadow_tag[s][r.way_used]   = t;
         shadow_valid[s][r.way_used] = 1'b1;
      end
      // move the used way to the front
      pos = NWAYS - 1;
      for (int k = NWAYS - 1; k >= 0; k--) begin
         if (shadow_order[s][k] == r.way_used) pos = k;
      end
      for (int k = pos; k > 0; k--) shadow_order[s][k] = shadow_order[s][k-1];
      shadow_order[s][0] = r.way_used;
      r.hit          = found;
      r.hit_count    = shadow_hits;
      r.access_count = shadow_accesses;
      return r;
   endfunction

   // compare one result transfer with the oldest expectation
   task automatic check_lookup(input logic [RSP_DATA_W-1:0] data);
      lookup_rsp_type got;
      lookup_rsp_type want;
      got = data;
      if (expected_lookups.size() == 0) begin
         fail_count++;
         if (fail_count <= REPORT_MAX) $display("unexpected result transfer: %h", data);
      end else begin
         want = expected_lookups.pop_front();
         if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
               $display({"mismatch: hit %b/%b way %0d/%0d hits %0d/%0d",
                         " accesses %0d/%0d pad %h/%h"},
                        want.hit, got.hit, want.way_used, got.way_used,
                        want.hit_count, got.hit_count, want.access_count, got.access_count,
                        want.pad, got.pad);
            end
         end
      end
   endtask

   // result side: check, then pick the next tready (bursts of stalls, one long hold)
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_lookup(rsp_tdata);
         if (stall_left == 0 && long_hold_req) begin
            stall_left    = LONG_HOLD;
            long_hold_req = 1'b0;
         end else if (stall_left == 0 && idle_en && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 4);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog: cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // offer one address, wait for the transfer, record what it should produce
   task automatic send_address(input logic [ADDR_BITS-1:0] addr);
      if (idle_en && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= addr;
      do @(posedge clock); while (!req_tready);
      expected_lookups.push_back(predict_lookup(addr));
   endtask

   // mostly tags from a small working set, some fully random addresses
   function automatic logic [ADDR_BITS-1:0] pick_address();
      logic [ADDR_BITS-1:0] a;
      a = $urandom;
      if ($urandom_range(0, 9) != 0)
         a[ADDR_BITS-1 -: TAG_W] = tag_pool[$urandom_range(0, pool_span - 1)];
      return a;
   endfunction

   function automatic void refill_pool();
      for (int i = 0; i < POOL_SIZE; i++) tag_pool[i] = TAG_W'($urandom);
      pool_span = $urandom_range(2, POOL_SIZE);
   endfunction

   // empty ways fill in order 0..3 in each set; address extremes; offset bits ignored
   task automatic test_empty_way_fill();
      logic [ADDR_BITS-1:0] seq [10] = '{
         32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFF8, 32'h0000_0008, 32'h0000_0010,
         32'h0000_0004, 32'h0000_000C, 32'h8000_0014, 32'h0000_0003, 32'hFFFF_FFFC};
      foreach (seq[i]) send_address(seq[i]);
   endtask

   // hits reorder recency, then misses evict the least recently used way
   task automatic test_lru_replace();
      logic [ADDR_BITS-1:0] seq [12] = '{
         32'h0000_0010, 32'h0000_0008, 32'h0000_0000, 32'h0000_0018, 32'hFFFF_FFF8,
         32'h0000_0020, 32'h0000_0028, 32'h0000_0010, 32'h7FFF_FFFC, 32'h0000_000C,
         32'hFFFF_FFFB, 32'h0000_0019};
      foreach (seq[i]) send_address(seq[i]);
   endtask

   // runs of back-to-back accesses to one set at a time with no gaps, hitting the same row repeatedly
   task automatic test_same_set_streak();
      logic [ADDR_BITS-1:0] a;
      idle_en = 1'b0;
      refill_pool();
      pool_span = 5;
      for (int i = 0; i < 60; i++) begin
         a = pick_address();
         a[OFFSET_BITS +: SET_W] = SET_W'(i / 20);
         send_address(a);
      end
      idle_en = 1'b1;
   endtask

   // long receiver hold while addresses keep coming, so the input stalls
   task automatic test_result_backpressure();
      idle_en       = 1'b0;
      long_hold_req = 1'b1;
      refill_pool();
      for (int i = 0; i < 40; i++) send_address(pick_address());
      idle_en = 1'b1;
   endtask

   // random traffic with changing working sets
   task automatic test_random_traffic(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) refill_pool();
         send_address(pick_address());
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      fail_count    = 0;
      quiet_cycles  = 0;
      idle_en       = 1'b1;
      long_hold_req = 1'b0;
      pool_span     = POOL_SIZE;
      clear_shadow();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_empty_way_fill();
      test_lru_replace();
      test_same_set_streak();
      test_result_backpressure();
      test_random_traffic(1100);
      // last part without idling on either side
      idle_en = 1'b0;
      test_random_traffic(200);

      req_tvalid <= 1'b0;
      while (expected_lookups.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
